// ===== rtl/core/packet_delay_hold_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// Packet delay hold queue assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_DELAY_HOLD_QUEUE_TOP_MACROS_SVH
`define PACKET_DELAY_HOLD_QUEUE_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define PDHQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define PDHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pdhq_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet delay hold queue package
// Sizes, codes and transfer types shared by the delay queue files.
// ----------------------------------------------------------------------------
package pdhq_pkg;

  localparam int unsigned DEPTH       = 32;
  localparam logic [31:0] BYTE_BUDGET = 32'd1048576;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LAG_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_DLY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_DLY = 3'd4;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_BUSY  = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] packet_tag;
    logic [15:0] packet_bytes;
    logic        direction;
    logic [63:0] now_ms;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] released_tag;
    logic        status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [63:0] arrival;
    logic [15:0] size;
    logic        dir;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic out_t status_res(logic status);
    out_t r;
    r.kind         = KIND_STATUS;
    r.released_tag = '0;
    r.status       = status;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic out_t release_res(logic [31:0] tag);
    out_t r;
    r.kind         = KIND_RELEASE;
    r.released_tag = tag;
    r.status       = STATUS_OK;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/pdhq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pdhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/packet_delay_hold_queue_top.sv =====
// ----------------------------------------------------------------------------
// Packet delay hold queue
// Holds packet tags for a per-direction delay and releases them in order.
//
//   channel  | direction | transfer on               | payload
//   ---------+-----------+---------------------------+-----------
//   in       | input     | in_valid_i & !in_stall_o  | in_t
//   out      | output    | out_valid_o & !out_stall_i| out_t
//   cfg      | input     | cfg_we_i                  | index, data
//
// Add and start go from idle to done. Tick and stop go through read, eval per held
// entry and done, or straight to done with an empty store: the scan reads one RAM
// entry per cycle unless an output stall holds it, and compacts survivors through
// the same RAM port pair. An output register lets the next item enter while a
// result waits. Reset clears the count, byte total and run flag; no clearing pass.
// ----------------------------------------------------------------------------
`include "packet_delay_hold_queue_top_macros.svh"

module packet_delay_hold_queue_top
  import pdhq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic        lag_en_q, in_en_q, out_en_q;
  logic [31:0] in_dly_q, out_dly_q;

  logic             running_q, running_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      total_q, total_d;
  logic [CNT_W-1:0] r_q, r_d;
  logic [CNT_W-1:0] kept_q, kept_d;
  logic [63:0]      now_q, now_d;
  logic             pvld_q, pvld_d;
  out_t             pdat_q, pdat_d;
  logic             ovld_q, ovld_d;
  out_t             odat_q, odat_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic             in_acc, o_free, hold, adv, last_ent, ent_ready;
  logic [CNT_W-1:0] r_next;
  logic [31:0]      budget_left, add_dly, ent_dly;
  logic [63:0]      elapsed;
  entry_t           new_ent;

  function automatic logic [31:0] cur_delay(logic run, logic lag, logic ien,
                                            logic [31:0] idly, logic oen,
                                            logic [31:0] odly, logic dir);
    logic [31:0] d;
    d = '0;
    if (run && lag) begin
      if (dir) begin
        d = oen ? odly : '0;
      end else begin
        d = ien ? idly : '0;
      end
    end
    return d;
  endfunction

  pdhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_acc = in_valid_i && !in_stall_o;
  assign o_free = !ovld_q || !out_stall_i;

  assign add_dly = cur_delay(running_q, lag_en_q, in_en_q, in_dly_q, out_en_q, out_dly_q,
                             in_data_i.direction);
  assign budget_left = BYTE_BUDGET - total_q;
  assign hold = (add_dly != '0) && (cnt_q < CNT_W'(DEPTH)) &&
                ({16'b0, in_data_i.packet_bytes} <= budget_left);

  assign new_ent.tag     = in_data_i.packet_tag;
  assign new_ent.arrival = in_data_i.now_ms;
  assign new_ent.size    = in_data_i.packet_bytes;
  assign new_ent.dir     = in_data_i.direction;

  assign ent_dly = cur_delay(running_q, lag_en_q, in_en_q, in_dly_q, out_en_q, out_dly_q,
                             ram_rdata.dir);
  assign elapsed   = now_q - ram_rdata.arrival;
  assign ent_ready = (ent_dly == '0) ||
                     ((now_q >= ram_rdata.arrival) && (elapsed >= {32'b0, ent_dly}));

  assign adv      = !(ent_ready && pvld_q && !o_free);
  assign r_next   = r_q + CNT_W'(1);
  assign last_ent = (r_next == cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.op == OP_TICK || in_data_i.op == OP_STOP) begin
            state_d = (cnt_q == '0) ? ST_DONE : ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (adv && last_ent) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (o_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_raddr  = r_q[IDX_W-1:0];
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[IDX_W-1:0];
    ram_wdata  = new_ent;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_we     = in_acc && (in_data_i.op == OP_ADD) && hold;
      end
      ST_READ: ram_re = 1'b1;
      ST_EVAL: begin
        ram_re    = adv && !last_ent;
        ram_raddr = r_next[IDX_W-1:0];
        ram_we    = adv && !ent_ready;
        ram_waddr = kept_q[IDX_W-1:0];
        ram_wdata = ram_rdata;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    running_d = running_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    r_d       = r_q;
    kept_d    = kept_q;
    now_d     = now_q;
    pvld_d    = pvld_q;
    pdat_d    = pdat_q;
    ovld_d    = ovld_q && out_stall_i;
    odat_d    = odat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          now_d  = in_data_i.now_ms;
          r_d    = '0;
          kept_d = '0;
          case (in_data_i.op)
            OP_ADD: begin
              pvld_d = 1'b1;
              if (hold) begin
                cnt_d   = cnt_q + CNT_W'(1);
                total_d = total_q + {16'b0, in_data_i.packet_bytes};
                pdat_d  = status_res(STATUS_OK);
              end else begin
                pdat_d  = release_res(in_data_i.packet_tag);
              end
            end
            OP_START: begin
              pvld_d = 1'b1;
              if (running_q) begin
                pdat_d    = status_res(STATUS_BUSY);
              end else begin
                running_d = 1'b1;
                pdat_d    = status_res(STATUS_OK);
              end
            end
            OP_STOP: running_d = 1'b0;
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        if (adv) begin
          r_d = r_next;
          if (ent_ready) begin
            total_d = total_q - {16'b0, ram_rdata.size};
            pvld_d  = 1'b1;
            pdat_d  = release_res(ram_rdata.tag);
            if (pvld_q) begin
              ovld_d = 1'b1;
              odat_d = pdat_q;
            end
          end else begin
            kept_d = kept_q + CNT_W'(1);
          end
          if (last_ent) begin
            cnt_d = ent_ready ? kept_q : kept_q + CNT_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (o_free) begin
          ovld_d = 1'b1;
          odat_d = pvld_q ? pdat_q : status_res(STATUS_OK);
          odat_d.last = 1'b1;
          pvld_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      running_q <= 1'b0;
      cnt_q     <= '0;
      total_q   <= '0;
      r_q       <= '0;
      kept_q    <= '0;
      pvld_q    <= 1'b0;
      ovld_q    <= 1'b0;
      lag_en_q  <= 1'b0;
      in_en_q   <= 1'b0;
      in_dly_q  <= '0;
      out_en_q  <= 1'b0;
      out_dly_q <= '0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      cnt_q     <= cnt_d;
      total_q   <= total_d;
      r_q       <= r_d;
      kept_q    <= kept_d;
      pvld_q    <= pvld_d;
      ovld_q    <= ovld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LAG_EN:  lag_en_q  <= cfg_wdata_i[0];
          CFG_IN_EN:   in_en_q   <= cfg_wdata_i[0];
          CFG_IN_DLY:  in_dly_q  <= cfg_wdata_i;
          CFG_OUT_EN:  out_en_q  <= cfg_wdata_i[0];
          CFG_OUT_DLY: out_dly_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    pdat_q <= pdat_d;
    odat_q <= odat_d;
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odat_q;

  `PDHQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "held count above depth")
  `PDHQ_ASSERT_NOW(a_idle_no_pend, state_q == ST_IDLE, !pvld_q, "pending result left in idle")
  `PDHQ_ASSERT_NOW(a_empty_bytes, cnt_q == '0, total_q == '0, "bytes held with empty store")
  `PDHQ_ASSERT_NEXT(a_stop_clears, in_acc && in_data_i.op == OP_STOP, !running_q,
                    "stop left block running")

endmodule
